FILE: hw/rtl/jvs_pkg.sv
// ----------------------------------------------------------------------------
// jvs_pkg - shared types and codes for the Jacobian visual servo step
// Command, status and register index codes, datapath widths, pipeline control.
// ----------------------------------------------------------------------------
package jvs_pkg;

  // Register indexes of the configuration port
  localparam logic [3:0] REG_JAC_A       = 4'd0;
  localparam logic [3:0] REG_JAC_B       = 4'd1;
  localparam logic [3:0] REG_JAC_C       = 4'd2;
  localparam logic [3:0] REG_JAC_D       = 4'd3;
  localparam logic [3:0] REG_DEADBAND    = 4'd4;
  localparam logic [3:0] REG_FIRST_AXIS  = 4'd5;
  localparam logic [3:0] REG_SECOND_AXIS = 4'd6;
  localparam logic [3:0] REG_INVERT      = 4'd7;

  // Result status codes
  localparam logic [1:0] ST_MOVE     = 2'd0;
  localparam logic [1:0] ST_DEADBAND = 2'd1;
  localparam logic [1:0] ST_SINGULAR = 2'd2;

  // Move command codes
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_BASE = 3'd1;   // 1 + 2*axis + negative

  localparam logic [1:0] AXIS_BAD = 2'd3;

  // Divider widths: dividend (2n+d) and divisor (2d)
  localparam int NUM_W  = 61;
  localparam int DEN_W  = 49;
  localparam int QUO_W  = 32;
  localparam int DIV_LAT = QUO_W + 1;

  // Control that rides alongside the divider
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       neg0;
    logic       neg1;
  } ctrl_t;

endpackage

FILE: hw/rtl/jacobian_visual_servo_step.sv
// ----------------------------------------------------------------------------
// jacobian_visual_servo_step - 2x2 Jacobian-inverse visual servo step
// Pixel error, deadband test, Jacobian inversion and direction command.
// ----------------------------------------------------------------------------
// One pixel pair enters per clock and one result leaves per clock while the
// output is not stalled; between input transfer and output valid lie four
// arithmetic stages, a 33-stage divider and the output register.
// The whole pipeline advances as one when the output register is empty or
// being taken, so a stall on the output holds every stage in place. The error
// (target - current, Q.6) is tested against deadband_px*64 on both components;
// otherwise the determinant a*d - b*c and the numerators d*du - b*dv and
// a*dv - c*du are formed exactly, and each step is numerator*2^18/det in
// Q24.8, rounded half away from zero and saturated to 32 bits. A zero
// determinant or an axis code of 3 reports status 2 with zero steps.
// Configuration registers must only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module jacobian_visual_servo_step (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [3:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // now_u, now_v, goal_u, goal_v
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // move_cmd[2:0], first_steps, second_steps, 0
  output logic [1:0]  out_tuser   // status
);

  localparam int NW  = jvs_pkg::NUM_W;
  localparam int DW  = jvs_pkg::DEN_W;
  localparam int LAT = jvs_pkg::DIV_LAT;

  // ---------------- configuration registers ----------------
  logic signed [23:0] jac_a_r, jac_b_r, jac_c_r, jac_d_r;
  logic [7:0]         deadband_r;
  logic [1:0]         first_axis_r, second_axis_r;
  logic [2:0]         invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jac_a_r       <= 24'sd13107;
      jac_b_r       <= '0;
      jac_c_r       <= '0;
      jac_d_r       <= 24'sd19661;
      deadband_r    <= 8'd5;
      first_axis_r  <= 2'd0;
      second_axis_r <= 2'd2;
      invert_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        jvs_pkg::REG_JAC_A:       jac_a_r       <= cfg_wdata;
        jvs_pkg::REG_JAC_B:       jac_b_r       <= cfg_wdata;
        jvs_pkg::REG_JAC_C:       jac_c_r       <= cfg_wdata;
        jvs_pkg::REG_JAC_D:       jac_d_r       <= cfg_wdata;
        jvs_pkg::REG_DEADBAND:    deadband_r    <= cfg_wdata[7:0];
        jvs_pkg::REG_FIRST_AXIS:  first_axis_r  <= cfg_wdata[1:0];
        jvs_pkg::REG_SECOND_AXIS: second_axis_r <= cfg_wdata[1:0];
        jvs_pkg::REG_INVERT:      invert_r      <= cfg_wdata[2:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------- pipeline advance ----------------
  // Advance everything when the output slot is free or being transferred.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: pixel error and deadband ----------------
  logic               v1_r;
  logic signed [16:0] du_r, dv_r;
  logic               dead_r;
  logic signed [16:0] du_nxt, dv_nxt;
  logic [16:0]        adu, adv;
  logic [13:0]        band;

  assign du_nxt = $signed({1'b0, in_tdata[47:32]}) - $signed({1'b0, in_tdata[15:0]});
  assign dv_nxt = $signed({1'b0, in_tdata[63:48]}) - $signed({1'b0, in_tdata[31:16]});
  assign adu    = du_nxt[16] ? 17'(-du_nxt) : du_nxt;
  assign adv    = dv_nxt[16] ? 17'(-dv_nxt) : dv_nxt;
  assign band   = {deadband_r, 6'b0};

  always_ff @(posedge clk) begin
    if (!rst_n)  v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      du_r   <= du_nxt;
      dv_r   <= dv_nxt;
      dead_r <= (adu <= {3'b0, band}) && (adv <= {3'b0, band});
    end
  end

  // ---------------- stage 2: products ----------------
  logic               v2_r, dead2_r;
  logic signed [47:0] ad_r, bc_r;
  logic signed [40:0] d_du_r, b_dv_r, a_dv_r, c_du_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dead2_r <= dead_r;
      ad_r    <= jac_a_r * jac_d_r;
      bc_r    <= jac_b_r * jac_c_r;
      d_du_r  <= jac_d_r * du_r;
      b_dv_r  <= jac_b_r * dv_r;
      a_dv_r  <= jac_a_r * dv_r;
      c_du_r  <= jac_c_r * du_r;
    end
  end

  // ---------------- stage 3: determinant, numerators, status ----------------
  logic               v3_r;
  logic signed [48:0] det_r;
  logic signed [41:0] num0_r, num1_r;
  logic [1:0]         st3_r;
  logic signed [48:0] det_nxt;
  logic [1:0]         st3_nxt;

  assign det_nxt = 49'(ad_r) - 49'(bc_r);

  always_comb begin
    if (dead2_r)
      st3_nxt = jvs_pkg::ST_DEADBAND;
    else if (det_nxt == '0 || first_axis_r == jvs_pkg::AXIS_BAD ||
             second_axis_r == jvs_pkg::AXIS_BAD)
      st3_nxt = jvs_pkg::ST_SINGULAR;
    else
      st3_nxt = jvs_pkg::ST_MOVE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= det_nxt;
      num0_r <= 42'(d_du_r) - 42'(b_dv_r);
      num1_r <= 42'(a_dv_r) - 42'(c_du_r);
      st3_r  <= st3_nxt;
    end
  end

  // ---------------- stage 4: magnitudes and rounding offset ----------------
  logic [47:0]   dmag;
  logic [40:0]   nmag0, nmag1;
  logic [NW-1:0] dvd0_r, dvd1_r;
  logic [DW-1:0] dvs_r;
  jvs_pkg::ctrl_t ctrl4_r;

  assign dmag  = det_r[48]  ? 48'(-det_r)  : det_r[47:0];
  assign nmag0 = num0_r[41] ? 41'(-num0_r) : num0_r[40:0];
  assign nmag1 = num1_r[41] ? 41'(-num1_r) : num1_r[40:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl4_r.valid <= 1'b0;
    end else if (en) begin
      ctrl4_r.valid  <= v3_r;
      ctrl4_r.status <= st3_r;
      ctrl4_r.neg0   <= num0_r[41] ^ det_r[48];
      ctrl4_r.neg1   <= num1_r[41] ^ det_r[48];
    end
  end
  // dividend = 2*(|num| << 18) + |det|, divisor = 2*|det|
  always_ff @(posedge clk) begin
    if (en) begin
      dvd0_r <= {1'b0, nmag0, 19'b0} + {13'b0, dmag};
      dvd1_r <= {1'b0, nmag1, 19'b0} + {13'b0, dmag};
      dvs_r  <= {dmag, 1'b0};
    end
  end

  // ---------------- divider stages ----------------
  logic [31:0] q0, q1;
  logic        sat0, sat1;

  jvs_div u_div0 (
    .clk   (clk),
    .en    (en),
    .num_i (dvd0_r),
    .den_i (dvs_r),
    .quo_o (q0),
    .sat_o (sat0)
  );

  jvs_div u_div1 (
    .clk   (clk),
    .en    (en),
    .num_i (dvd1_r),
    .den_i (dvs_r),
    .quo_o (q1),
    .sat_o (sat1)
  );

  // Control rides a delay line matched to the divider latency
  jvs_pkg::ctrl_t ctrl_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) ctrl_r[i].valid <= 1'b0;
    end else if (en) begin
      ctrl_r[0] <= ctrl4_r;
      for (int i = 1; i < LAT; i++) ctrl_r[i] <= ctrl_r[i-1];
    end
  end

  // ---------------- final stage: saturate, pick axis, command ----------------
  function automatic logic [31:0] sat_step(input logic [31:0] q, input logic sat,
                                           input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (sat || (q[31] && (q[30:0] != '0))) r = 32'h8000_0000;
      else                                   r = 32'(-q);
    end else begin
      if (sat || q[31]) r = 32'h7FFF_FFFF;
      else              r = q;
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic [31:0] s);
    return s[31] ? 33'(-{1'b1, s}) : {1'b0, s};
  endfunction

  function automatic logic [2:0] dir_cmd(input logic [1:0] axis, input logic [31:0] s,
                                         input logic [2:0] inv);
    logic neg;
    neg = s[31] ^ inv[axis];
    return jvs_pkg::CMD_BASE + {axis, 1'b0} + {2'b0, neg};
  endfunction

  jvs_pkg::ctrl_t cf;
  logic [31:0] s0, s1;
  logic [2:0]  cmd_nxt;
  logic        out_valid_r;
  logic [2:0]  move_cmd_r;
  logic [31:0] first_steps_r, second_steps_r;
  logic [1:0]  status_r;

  assign cf = ctrl_r[LAT-1];
  assign s0 = sat_step(q0, sat0, cf.neg0);
  assign s1 = sat_step(q1, sat1, cf.neg1);

  always_comb begin
    if (mag33(s0) >= mag33(s1)) cmd_nxt = dir_cmd(first_axis_r, s0, invert_r);
    else                        cmd_nxt = dir_cmd(second_axis_r, s1, invert_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= cf.valid;
  end
  // Zero the payload for deadband and singular results
  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= cf.status;
      if (cf.status == jvs_pkg::ST_MOVE) begin
        move_cmd_r     <= cmd_nxt;
        first_steps_r  <= s0;
        second_steps_r <= s1;
      end else begin
        move_cmd_r     <= jvs_pkg::CMD_NONE;
        first_steps_r  <= '0;
        second_steps_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, second_steps_r, first_steps_r, move_cmd_r};
  assign out_tuser  = status_r;

  // ---------------- assertions ----------------
  a_move_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == jvs_pkg::ST_MOVE |-> out_tdata[2:0] != jvs_pkg::CMD_NONE)
    else $error("move result without a command");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jvs_pkg::ST_MOVE |->
      out_tdata[2:0] == jvs_pkg::CMD_NONE && out_tdata[66:3] == '0)
    else $error("non-move result carries a payload");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

FILE: hw/rtl/jvs_div.sv
// ----------------------------------------------------------------------------
// jvs_div - pipelined restoring divider with saturation flag
// First stage flags quotients of 2^32 or more; then one quotient bit a stage.
// ----------------------------------------------------------------------------
module jvs_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [jvs_pkg::NUM_W-1:0]      num_i,
  input  logic [jvs_pkg::DEN_W-1:0]      den_i,
  output logic [jvs_pkg::QUO_W-1:0]      quo_o,
  output logic                           sat_o
);

  localparam int NW = jvs_pkg::NUM_W;
  localparam int DW = jvs_pkg::DEN_W;
  localparam int QW = jvs_pkg::QUO_W;
  localparam int SW = NW + QW;

  logic [NW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          sat_r [QW+1];

  // Quotient overflows when floor(num / 2^32) >= den
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      quo_r[0] <= '0;
      sat_r[0] <= ({{(DW-(NW-QW)){1'b0}}, num_i[NW-1:QW]} >= den_i);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [SW-1:0] dsh;
    logic          ge;
    assign dsh = {{(SW-DW){1'b0}}, den_r[k]} << BIT;
    assign ge  = {{(SW-NW){1'b0}}, rem_r[k]} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (rem_r[k] - dsh[NW-1:0]) : rem_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_r[k] | (ge ? (QW'(1) << BIT) : '0);
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign quo_o = quo_r[QW];
  assign sat_o = sat_r[QW];

endmodule
